// ===== src/olte_pkg.sv =====
// Shared types and codes for the ordered list table engine.
package olte_pkg;

  typedef enum logic [2:0] {
    FN_APPEND  = 3'd0,
    FN_DELETE  = 3'd1,
    FN_MAX     = 3'd2,
    FN_PRINT   = 3'd3,
    FN_REVERSE = 3'd4,
    FN_UPDATE  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_NOTFOUND = 3'd2,
    KIND_BADPOS   = 3'd3,
    KIND_FULL     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIST_F,
    ST_LIST_R,
    ST_MAX,
    ST_MAX_OUT,
    ST_UPD,
    ST_UPD_CHK,
    ST_DEL_RD,
    ST_DEL_CAP,
    ST_DEL_SH,
    ST_DEL_END
  } st_e;

  typedef enum logic [1:0] {
    RS_IDX,
    RS_REV,
    RS_NEXT
  } rsel_e;

  typedef enum logic [1:0] {
    IS_ZERO,
    IS_RDATA,
    IS_BEST
  } isel_e;

  typedef struct packed {
    logic  latch;
    logic  app_wr;
    logic  idx_clr;
    logic  idx_pos;
    logic  idx_inc;
    logic  rd_en;
    rsel_e rsel;
    logic  rd_last;
    logic  shift;
    logic  acc;
    logic  upd;
    logic  hit_clr;
    logic  best_cap;
    logic  cnt_dec;
    logic  emit;
    kind_e kind;
    isel_e isel;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_bad;
    logic idx_lt;
    logic idx_last;
    logic nxt_ok;
    logic rv;
    logic rl;
    logic hit;
  } sts_t;

endpackage

// ===== src/ordered_list_table_engine.sv =====
// Top level of the ordered list table engine.
//
// Keeps an ordered list of up to DEPTH signed 32-bit values. An item
// (func_i, value_i, position_i, new_value_i) is taken at a clock edge where
// start is high and busy is low. Results leave on kind_o, item_o and last_o,
// each valid for exactly one cycle while res_valid_o is high; last_o marks
// the final result of an item. The receiver cannot stall the block.
// A rejected or empty-list item gives a single result and leaves the block idle.
// The entry memory has one read and one write port and is walked one entry
// per cycle; busy stays high while an item is in progress, so a new item is
// taken only once the previous one is through. An update with a match walks
// the list twice, once to rewrite the matches and once to print the list.
// Reset clears the entry count and the control state; the entry memory
// itself is not cleared and needs no sweep.
module ordered_list_table_engine #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] value_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] new_value_i,
  output logic               res_valid_o,
  output logic [2:0]         kind_o,
  output logic signed [31:0] item_o,
  output logic               last_o
);
  import olte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  olte_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (value_i),
    .position_i  (position_i),
    .new_value_i (new_value_i),
    .res_valid_o (res_valid_o),
    .kind_o      (kind_o),
    .item_o      (item_o),
    .last_o      (last_o)
  );

endmodule

// ===== src/olte_ctrl.sv =====
// Controller state machine for the ordered list table engine.
module olte_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic [2:0]     func_i,
  input  olte_pkg::sts_t sts_i,
  output olte_pkg::cmd_t cmd_o,
  output logic           busy
);
  import olte_pkg::*;

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (func_e'(func_i))
            FN_APPEND:  if (!sts_i.full) state_d = ST_LIST_F;
            FN_DELETE:  if (!sts_i.pos_bad) state_d = ST_DEL_RD;
            FN_MAX:     if (!sts_i.empty) state_d = ST_MAX;
            FN_PRINT:   if (!sts_i.empty) state_d = ST_LIST_F;
            FN_REVERSE: if (!sts_i.empty) state_d = ST_LIST_R;
            FN_UPDATE:  if (!sts_i.empty) state_d = ST_UPD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_LIST_F, ST_LIST_R: if (sts_i.rl) state_d = ST_IDLE;
      ST_MAX:     if (sts_i.rl) state_d = ST_MAX_OUT;
      ST_MAX_OUT: state_d = ST_IDLE;
      ST_UPD:     if (sts_i.rl) state_d = ST_UPD_CHK;
      ST_UPD_CHK: state_d = sts_i.hit ? ST_LIST_F : ST_IDLE;
      ST_DEL_RD:  state_d = ST_DEL_CAP;
      ST_DEL_CAP, ST_DEL_SH: state_d = sts_i.nxt_ok ? ST_DEL_SH : ST_DEL_END;
      ST_DEL_END: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rsel = RS_IDX;
    cmd_o.kind = KIND_DATA;
    cmd_o.isel = IS_ZERO;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (func_e'(func_i))
            FN_APPEND: begin
              if (sts_i.full) begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = KIND_FULL;
                cmd_o.last = 1'b1;
              end else begin
                cmd_o.app_wr  = 1'b1;
                cmd_o.idx_clr = 1'b1;
              end
            end
            FN_DELETE: begin
              if (sts_i.pos_bad) begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = KIND_BADPOS;
                cmd_o.last = 1'b1;
              end else begin
                cmd_o.idx_pos = 1'b1;
              end
            end
            FN_MAX, FN_PRINT, FN_REVERSE, FN_UPDATE: begin
              if (sts_i.empty) begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = KIND_EMPTY;
                cmd_o.last = 1'b1;
              end else begin
                cmd_o.idx_clr = 1'b1;
                cmd_o.hit_clr = 1'b1;
                cmd_o.latch   = 1'b1;
              end
            end
            default: cmd_o.emit = 1'b0;
          endcase
        end
      end
      ST_LIST_F, ST_LIST_R, ST_MAX, ST_UPD: begin
        cmd_o.rd_en   = sts_i.idx_lt;
        cmd_o.idx_inc = sts_i.idx_lt;
        cmd_o.rd_last = sts_i.idx_last;
        cmd_o.rsel    = (state_q == ST_LIST_R) ? RS_REV : RS_IDX;
        cmd_o.acc     = (state_q == ST_MAX);
        cmd_o.upd     = (state_q == ST_UPD);
        if (state_q == ST_LIST_F || state_q == ST_LIST_R) begin
          cmd_o.emit = sts_i.rv;
          cmd_o.isel = IS_RDATA;
          cmd_o.last = sts_i.rl;
        end
      end
      ST_MAX_OUT, ST_DEL_END: begin
        cmd_o.emit    = 1'b1;
        cmd_o.isel    = IS_BEST;
        cmd_o.last    = 1'b1;
        cmd_o.cnt_dec = (state_q == ST_DEL_END);
      end
      ST_UPD_CHK: begin
        if (sts_i.hit) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_NOTFOUND;
          cmd_o.last = 1'b1;
        end
      end
      ST_DEL_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_DEL_CAP, ST_DEL_SH: begin
        cmd_o.best_cap = (state_q == ST_DEL_CAP);
        cmd_o.rd_en    = sts_i.nxt_ok;
        cmd_o.rsel     = RS_NEXT;
        cmd_o.shift    = sts_i.nxt_ok;
        cmd_o.idx_inc  = sts_i.nxt_ok;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

endmodule

// ===== src/olte_dp.sv =====
// Datapath of the ordered list table engine: entry memory, count, index and result register.
module olte_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  olte_pkg::cmd_t     cmd_i,
  output olte_pkg::sts_t     sts_o,
  input  logic signed [31:0] value_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] new_value_i,
  output logic               res_valid_o,
  output logic [2:0]         kind_o,
  output logic signed [31:0] item_o,
  output logic               last_o
);
  import olte_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 6) ? CW : 6;

  logic signed [31:0] mem [DEPTH];

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW:0]        idx_p1;
  logic [CW-1:0]      rev_addr;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      ra_q;
  logic signed [31:0] rdata_q;
  logic               rv_q, rl_q, rf_q;
  logic               sw_q;
  logic [AW-1:0]      swa_q;
  logic               hit_q;
  logic signed [31:0] best_q;
  logic signed [31:0] value_q, nvalue_q;
  logic               upd_hit;
  logic               wr_en;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               out_vld_q;
  logic [2:0]         kind_q;
  logic signed [31:0] item_q;
  logic               last_q;
  logic signed [31:0] item_d;

  assign idx_p1   = {1'b0, idx_q} + 1'b1;
  assign rev_addr = count_q - idx_q - 1'b1;
  assign upd_hit  = cmd_i.upd && rv_q && (rdata_q == value_q);

  always_comb begin
    case (cmd_i.rsel)
      RS_IDX:  raddr = idx_q[AW-1:0];
      RS_REV:  raddr = rev_addr[AW-1:0];
      RS_NEXT: raddr = idx_p1[AW-1:0];
      default: raddr = idx_q[AW-1:0];
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.app_wr) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_pos) begin
      idx_d = CW'(position_i);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1[CW-1:0];
    end
  end

  always_comb begin
    wr_en = 1'b1;
    waddr = count_q[AW-1:0];
    wdata = value_i;
    if (cmd_i.app_wr) begin
      waddr = count_q[AW-1:0];
      wdata = value_i;
    end else if (sw_q) begin
      waddr = swa_q;
      wdata = rdata_q;
    end else if (upd_hit) begin
      waddr = ra_q;
      wdata = nvalue_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.isel)
      IS_RDATA: item_d = rdata_q;
      IS_BEST:  item_d = best_q;
      default:  item_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      rv_q      <= 1'b0;
      rl_q      <= 1'b0;
      rf_q      <= 1'b0;
      sw_q      <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      idx_q     <= idx_d;
      rv_q      <= cmd_i.rd_en;
      rl_q      <= cmd_i.rd_en && cmd_i.rd_last;
      rf_q      <= cmd_i.rd_en && (idx_q == '0);
      sw_q      <= cmd_i.shift;
      out_vld_q <= cmd_i.emit;
      if (cmd_i.hit_clr) begin
        hit_q <= 1'b0;
      end else if (upd_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
      ra_q    <= raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    swa_q <= idx_q[AW-1:0];
    if (cmd_i.latch) begin
      value_q  <= value_i;
      nvalue_q <= new_value_i;
    end
    if (cmd_i.best_cap) begin
      best_q <= rdata_q;
    end else if (cmd_i.acc && rv_q && (rf_q || (rdata_q > best_q))) begin
      best_q <= rdata_q;
    end
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      item_q <= item_d;
      last_q <= cmd_i.last;
    end
  end

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.pos_bad  = (PW'(position_i) >= PW'(count_q));
  assign sts_o.idx_lt   = (idx_q < count_q);
  assign sts_o.idx_last = (idx_p1 == {1'b0, count_q});
  assign sts_o.nxt_ok   = (idx_p1 < {1'b0, count_q});
  assign sts_o.rv       = rv_q;
  assign sts_o.rl       = rl_q;
  assign sts_o.hit      = hit_q;

  assign res_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign item_o      = item_q;
  assign last_o      = last_q;

endmodule

// ===== src/olte_chk.sv =====
// Port-level checker for the ordered list table engine and its bind.
module olte_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy,
  input logic               res_valid_o,
  input logic [2:0]         kind_o,
  input logic signed [31:0] item_o,
  input logic               last_o
);
  import olte_pkg::*;

  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> res_valid_o)
    else $error("result burst broken before last item");

  a_status_zero_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o != KIND_DATA) |-> (item_o == '0))
    else $error("status result carries nonzero item");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o != KIND_DATA) |-> last_o)
    else $error("status result not marked last");

  a_busy_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |-> busy)
    else $error("block idle while results still pending");

endmodule

bind ordered_list_table_engine olte_chk u_olte_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .kind_o      (kind_o),
  .item_o      (item_o),
  .last_o      (last_o)
);

// ===== sim/ordered_list_table_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list table engine: directed and random list operations.
module ordered_list_table_engine_tb;
  import olte_pkg::*;

  localparam int unsigned LIST_DEPTH   = 32;
  localparam int          RANDOM_ITEMS = 200;
  localparam int          QUIET_ITEMS  = 40;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] elem;
    logic               last;
  } list_out_t;

  class list_tracker;
    logic signed [31:0] entries [LIST_DEPTH];
    int unsigned        count;
    list_out_t          pending_out [$];
    int                 errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void emit(kind_e k, logic signed [31:0] e, logic l);
      list_out_t r;
      r.kind = k;
      r.elem = e;
      r.last = l;
      pending_out.push_back(r);
    endfunction

    function void emit_list(bit rev);
      if (count == 0) begin
        emit(KIND_EMPTY, '0, 1'b1);
      end else begin
        for (int i = 0; i < count; i++) begin
          emit(KIND_DATA, entries[rev ? count - 1 - i : i], i == count - 1);
        end
      end
    endfunction

    function void take_op(logic [2:0] f, logic signed [31:0] v, logic [5:0] p,
                          logic signed [31:0] nv);
      logic signed [31:0] best;
      logic signed [31:0] removed;
      bit                 hit;
      case (f)
        FN_APPEND: begin
          if (count >= LIST_DEPTH) begin
            emit(KIND_FULL, '0, 1'b1);
          end else begin
            entries[count] = v;
            count++;
            emit_list(1'b0);
          end
        end
        FN_DELETE: begin
          if (p >= count) begin
            emit(KIND_BADPOS, '0, 1'b1);
          end else begin
            removed = entries[p];
            for (int i = p; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
            emit(KIND_DATA, removed, 1'b1);
          end
        end
        FN_MAX: begin
          if (count == 0) begin
            emit(KIND_EMPTY, '0, 1'b1);
          end else begin
            best = entries[0];
            for (int i = 1; i < count; i++) if (entries[i] > best) best = entries[i];
            emit(KIND_DATA, best, 1'b1);
          end
        end
        FN_PRINT:   emit_list(1'b0);
        FN_REVERSE: emit_list(1'b1);
        FN_UPDATE: begin
          if (count == 0) begin
            emit(KIND_EMPTY, '0, 1'b1);
          end else begin
            hit = 1'b0;
            for (int i = 0; i < count; i++) begin
              if (entries[i] == v) begin
                entries[i] = nv;
                hit = 1'b1;
              end
            end
            if (hit) emit_list(1'b0);
            else emit(KIND_NOTFOUND, '0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task match_result(logic [2:0] k, logic signed [31:0] e, logic l);
      list_out_t want;
      if (pending_out.size() == 0) begin
        report($sformatf("unexpected result kind %0d item %0d last %0b", k, e, l));
        return;
      end
      want = pending_out.pop_front();
      if (k !== want.kind) report($sformatf("kind %0d, want %0d", k, want.kind));
      if (e !== want.elem) report($sformatf("item %0d, want %0d", e, want.elem));
      if (l !== want.last) report($sformatf("last %0b, want %0b", l, want.last));
    endtask

    task final_check();
      while (pending_out.size() > 0) begin
        report($sformatf("missing result kind %0d item %0d", pending_out[0].kind,
                         pending_out[0].elem));
        void'(pending_out.pop_front());
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         func_i;
  logic signed [31:0] value_i;
  logic [5:0]         position_i;
  logic signed [31:0] new_value_i;
  logic               res_valid_o;
  logic [2:0]         kind_o;
  logic signed [31:0] item_o;
  logic               last_o;

  list_tracker tracker;

  always #6 clk_i = ~clk_i;

  ordered_list_table_engine #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func_i),
    .value_i    (value_i),
    .position_i (position_i),
    .new_value_i(new_value_i),
    .res_valid_o(res_valid_o),
    .kind_o     (kind_o),
    .item_o     (item_o),
    .last_o     (last_o)
  );

  task automatic send_op(logic [2:0] f, logic signed [31:0] v, logic [5:0] p,
                         logic signed [31:0] nv);
    start       <= 1'b1;
    func_i      <= f;
    value_i     <= v;
    position_i  <= p;
    new_value_i <= nv;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.take_op(f, v, p, nv);
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid_o === 1'b1) tracker.match_result(kind_o, item_o, last_o);
  end

  initial begin
    #3_000_000;
    $display("ordered_list_table_engine_tb: errors");
    $finish;
  end

  initial begin
    int                 n;
    int                 r;
    int                 app_lim;
    int                 del_lim;
    logic [2:0]         f;
    logic signed [31:0] v;
    logic signed [31:0] nv;
    logic [5:0]         p;
    tracker     = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    func_i      = '0;
    value_i     = '0;
    position_i  = '0;
    new_value_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(FN_PRINT, 0, 0, 0);
    send_op(FN_REVERSE, 0, 0, 0);
    send_op(FN_MAX, 0, 0, 0);
    send_op(FN_UPDATE, 1, 0, 2);
    send_op(FN_DELETE, 0, 0, 0);
    send_op(FN_APPEND, 32'sh8000_0000, 0, 0);
    send_op(FN_APPEND, 32'sh7fff_ffff, 0, 0);
    send_op(FN_APPEND, 0, 0, 0);
    send_op(FN_APPEND, -1, 0, 0);
    send_op(FN_APPEND, 5, 0, 0);
    send_op(FN_APPEND, 5, 0, 0);
    send_op(FN_MAX, 0, 0, 0);
    send_op(FN_PRINT, 0, 0, 0);
    send_op(FN_REVERSE, 0, 0, 0);
    send_op(FN_UPDATE, 5, 0, -7);
    send_op(FN_UPDATE, 12345, 0, 1);
    send_op(FN_DELETE, 0, 63, 0);
    send_op(FN_DELETE, 0, 6, 0);
    send_op(FN_DELETE, 0, 5, 0);
    send_op(FN_DELETE, 0, 0, 0);
    send_op(FN_DELETE, 0, 1, 0);
    send_op(3'd6, -1, 63, -1);
    send_op(3'd7, 0, 0, 0);
    send_op(FN_MAX, 0, 0, 0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ((n / 40) % 3)
        0: begin
          app_lim = 75;
          del_lim = 82;
        end
        1: begin
          app_lim = 30;
          del_lim = 55;
        end
        default: begin
          app_lim = 12;
          del_lim = 65;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < app_lim) begin
        f = FN_APPEND;
      end else if (r < del_lim) begin
        f = FN_DELETE;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3:     f = FN_MAX;
          4, 5, 6, 7:     f = FN_PRINT;
          8, 9, 10, 11:   f = FN_REVERSE;
          19:             f = 3'($urandom_range(6, 7));
          default:        f = FN_UPDATE;
        endcase
      end
      v  = pick_value();
      nv = pick_value();
      p  = 6'($urandom_range(0, 63));
      if (f == FN_UPDATE && tracker.count > 0 && $urandom_range(0, 9) < 7) begin
        v = tracker.entries[$urandom_range(0, tracker.count - 1)];
      end
      if (f == FN_DELETE && tracker.count > 0 && $urandom_range(0, 9) < 8) begin
        p = 6'($urandom_range(0, tracker.count - 1));
      end
      if (n < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0) begin
        idle_gap($urandom_range(1, 8));
      end
      send_op(f, v, p, nv);
      if (f <= FN_UPDATE) n++;
    end
    start <= 1'b0;

    for (int w = 0; w < 20000 && tracker.pending_out.size() != 0; w++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    tracker.final_check();
    if (tracker.errors == 0) begin
      $display("ordered_list_table_engine_tb: clean");
    end else begin
      $display("ordered_list_table_engine_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/olte_pkg.sv
src/olte_ctrl.sv
src/olte_dp.sv
src/ordered_list_table_engine.sv
src/olte_chk.sv
sim/ordered_list_table_engine_tb.sv
